FILE: rtl/core/fbbt_pkg.sv
// Shared widths, register indexes and trim mode codes for the
// foreground bounding box block. No dependencies.
`timescale 1ns / 1ps

package fbbt_pkg;

  localparam int ValW    = 16;
  localparam int CoordW  = 10;
  localparam int AmtW    = 11;
  localparam int OutW    = 13;
  localparam int AxesOut = 3;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 16;
  localparam int ModeW   = 2;

  localparam logic [CfgIdxW-1:0] CfgBackground = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgTrimMode   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgAmountX    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgAmountY    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgAmountZ    = 3'd4;

  localparam logic [ModeW-1:0] ModePlain  = 2'd0;
  localparam logic [ModeW-1:0] ModeMargin = 2'd1;
  localparam logic [ModeW-1:0] ModeFinal  = 2'd2;

  typedef logic [CoordW-1:0] coord_t;
  typedef logic [OutW-1:0]   box_val_t;

endpackage

FILE: rtl/core/foreground_bounding_box_trim.sv
// Foreground bounding box over a voxel stream with margin and final-size trim.
// A last voxel's box goes to the stage-1 snapshot, then the output registers.
// Throughput: one voxel per cycle, into the box accumulators, unless in_stall.
// Reset (rst_n, synchronous): clears config, found flag and pipeline valids.
// Depends on fbbt_pkg.
`timescale 1ns / 1ps

module foreground_bounding_box_trim #(
  parameter int EXTENT_MAX = 1024,
  parameter int NUM_AXES   = 3
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [fbbt_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [fbbt_pkg::CfgW-1:0]           cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [fbbt_pkg::ValW-1:0]    in_voxel_value,
  input  logic [fbbt_pkg::CoordW-1:0]         in_coord_x,
  input  logic [fbbt_pkg::CoordW-1:0]         in_coord_y,
  input  logic [fbbt_pkg::CoordW-1:0]         in_coord_z,
  input  logic                                in_last_voxel,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [fbbt_pkg::OutW-1:0]    out_start_x,
  output logic signed [fbbt_pkg::OutW-1:0]    out_start_y,
  output logic signed [fbbt_pkg::OutW-1:0]    out_start_z,
  output logic [fbbt_pkg::OutW-1:0]           out_size_x,
  output logic [fbbt_pkg::OutW-1:0]           out_size_y,
  output logic [fbbt_pkg::OutW-1:0]           out_size_z,
  output logic                                out_box_empty
);

  localparam int AxW = fbbt_pkg::AxesOut;
  localparam logic [16:0] ExtLim = 17'(EXTENT_MAX);
  localparam fbbt_pkg::coord_t SatVal = fbbt_pkg::CoordW'(EXTENT_MAX - 1);

  // configuration
  logic signed [fbbt_pkg::ValW-1:0]  bg_r;
  logic [fbbt_pkg::ModeW-1:0]        mode_r;
  logic [fbbt_pkg::AmtW-1:0]         amt_x_r, amt_y_r, amt_z_r;
  logic [fbbt_pkg::AmtW-1:0]         amt [AxW];
  fbbt_pkg::coord_t                  coord [AxW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_r    <= '0;
      mode_r  <= fbbt_pkg::ModePlain;
      amt_x_r <= '0;
      amt_y_r <= '0;
      amt_z_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        fbbt_pkg::CfgBackground: bg_r    <= cfg_wdata;
        fbbt_pkg::CfgTrimMode:   mode_r  <= cfg_wdata[fbbt_pkg::ModeW-1:0];
        fbbt_pkg::CfgAmountX:    amt_x_r <= cfg_wdata[fbbt_pkg::AmtW-1:0];
        fbbt_pkg::CfgAmountY:    amt_y_r <= cfg_wdata[fbbt_pkg::AmtW-1:0];
        fbbt_pkg::CfgAmountZ:    amt_z_r <= cfg_wdata[fbbt_pkg::AmtW-1:0];
        default: ;
      endcase
    end
  end

  assign amt[0]   = amt_x_r;
  assign amt[1]   = amt_y_r;
  assign amt[2]   = amt_z_r;
  assign coord[0] = in_coord_x;
  assign coord[1] = in_coord_y;
  assign coord[2] = in_coord_z;

  // handshake
  logic in_acc, acc_last, s1_go;
  logic s1_vld_r, s1_vld_nxt, out_vld_r, out_vld_nxt;
  logic hit;
  logic found_r, found_nxt, s1_found_r, empty_r;

  assign s1_go     = ~out_vld_r | ~out_stall;
  assign in_stall  = s1_vld_r & ~s1_go;
  assign in_acc    = in_valid & ~in_stall;
  assign acc_last  = in_acc & in_last_voxel;
  assign out_valid = out_vld_r;
  assign hit       = (in_voxel_value != bg_r);
  assign found_nxt = found_r | hit;

  always_comb begin
    if (s1_go) begin
      s1_vld_nxt = acc_last;
    end else begin
      s1_vld_nxt = s1_vld_r | acc_last;
    end
    out_vld_nxt = s1_vld_r | (out_vld_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r   <= 1'b0;
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (in_acc) begin
        found_r <= in_last_voxel ? 1'b0 : found_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_last) begin
      s1_found_r <= found_nxt;
    end
    if (s1_go && s1_vld_r) begin
      empty_r <= ~s1_found_r;
    end
  end

  fbbt_pkg::box_val_t start_q [AxW];
  fbbt_pkg::box_val_t size_q  [AxW];

  for (genvar a = 0; a < AxW; a++) begin : g_axis
    if (a < NUM_AXES) begin : g_trk
      fbbt_pkg::coord_t   c_sat, min_r, max_r, min_nxt, max_nxt, s1_min_r, s1_max_r;
      fbbt_pkg::box_val_t st0, sz0, st, sz, start_r, size_r;

      assign c_sat = ({7'd0, coord[a]} >= ExtLim) ? SatVal : coord[a];

      always_comb begin
        min_nxt = min_r;
        max_nxt = max_r;
        if (hit) begin
          if (!found_r) begin
            min_nxt = c_sat;
            max_nxt = c_sat;
          end else begin
            if (c_sat < min_r) min_nxt = c_sat;
            if (c_sat > max_r) max_nxt = c_sat;
          end
        end
      end

      always_ff @(posedge clk) begin
        if (in_acc) begin
          min_r <= min_nxt;
          max_r <= max_nxt;
        end
        if (acc_last) begin
          s1_min_r <= min_nxt;
          s1_max_r <= max_nxt;
        end
      end

      // plain box, then trim
      always_comb begin
        if (s1_found_r) begin
          st0 = fbbt_pkg::OutW'(s1_min_r);
          sz0 = fbbt_pkg::OutW'(s1_max_r - s1_min_r) + fbbt_pkg::OutW'(1);
        end else begin
          st0 = '0;
          sz0 = '0;
        end
        case (mode_r)
          fbbt_pkg::ModeMargin: begin
            st = st0 - fbbt_pkg::OutW'(amt[a]);
            sz = sz0 + {1'b0, amt[a], 1'b0};
          end
          fbbt_pkg::ModeFinal: begin
            st = st0 + {1'b0, sz0[fbbt_pkg::OutW-1:1]}
                 - fbbt_pkg::OutW'(amt[a][fbbt_pkg::AmtW-1:1]);
            sz = fbbt_pkg::OutW'(amt[a]);
          end
          default: begin
            st = st0;
            sz = sz0;
          end
        endcase
      end

      always_ff @(posedge clk) begin
        if (s1_go && s1_vld_r) begin
          start_r <= st;
          size_r  <= sz;
        end
      end

      assign start_q[a] = start_r;
      assign size_q[a]  = size_r;
    end else begin : g_off
      assign start_q[a] = '0;
      assign size_q[a]  = '0;
    end
  end

  assign out_start_x   = $signed(start_q[0]);
  assign out_start_y   = $signed(start_q[1]);
  assign out_start_z   = $signed(start_q[2]);
  assign out_size_x    = size_q[0];
  assign out_size_y    = size_q[1];
  assign out_size_z    = size_q[2];
  assign out_box_empty = empty_r;

`ifndef SYNTH
  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    acc_last |=> !found_r)
    else $error("found flag not cleared after last voxel");

  a_last_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    acc_last |=> s1_vld_r)
    else $error("last voxel did not reach snapshot stage");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_vld_r && out_vld_r && out_stall))
    else $error("input stalled without a blocked result");

  a_plain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_box_empty && mode_r == fbbt_pkg::ModePlain)
      |-> (out_size_x == '0 && out_start_x == '0))
    else $error("empty plain box not zero");

  a_plain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_box_empty && mode_r == fbbt_pkg::ModePlain)
      |-> (out_size_x != '0 && out_size_y != '0))
    else $error("found box has zero size");
`endif

endmodule
